@@ sv/sliding_window_median_assert.svh @@
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// invariant checked at every clock edge outside reset
`define SWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in the cycle after a trigger
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/swm_pkg.sv @@
package swm_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int RESULT_W    = 33;
	localparam int CFG_W       = 7;
	localparam int DEPTH_DEF   = 64;
	localparam int LEN_RESET   = 3;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_REMOVE,
		ST_INSERT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic read;
		logic remove;
		logic insert;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic will_emit;
		logic out_free;
	} sts_t;

endpackage

@@ sv/swm_in_if.sv @@
interface swm_in_if;
	import swm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       start_sequence;

	modport source (output valid, output sample, output start_sequence, input ready);
	modport sink (input valid, input sample, input start_sequence, output ready);
endinterface

@@ sv/swm_out_if.sv @@
interface swm_out_if;
	import swm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [RESULT_W-1:0] median_doubled;

	modport source (output valid, output median_doubled, input ready);
	modport sink (input valid, input median_doubled, output ready);
endinterface

@@ sv/swm_ctrl.sv @@
module swm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  swm_pkg::sts_t  sts,
	output swm_pkg::cmd_t  cmd
);
	import swm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = sts.full ? ST_REMOVE : ST_INSERT;
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = sts.will_emit ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`include "sliding_window_median_assert.svh"

	`SWM_ASSERT(a_one_cmd, $onehot0(cmd), "more than one datapath command")
	`SWM_ASSERT_NEXT(a_remove_then_insert, cmd.remove, cmd.insert, "remove not followed by insert")
	`SWM_ASSERT_NEXT(a_take_then_read, cmd.take, cmd.read, "accepted sample not read")
endmodule

@@ sv/swm_dp.sv @@
module swm_dp #(
	parameter int DEPTH = swm_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swm_pkg::cmd_t                       cmd,
	output swm_pkg::sts_t                       sts,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                in_start,
	input  logic                                cfg_we,
	input  logic [swm_pkg::CFG_W-1:0]           cfg_len,
	output logic [swm_pkg::CFG_W-1:0]           len_rd,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [swm_pkg::RESULT_W-1:0] out_median
);
	import swm_pkg::*;

	localparam int LW = $clog2(DEPTH + 1);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [LW-1:0]               len_q, fill_q;
	logic [PW-1:0]               ptr_q;
	logic signed [SAMPLE_W-1:0]  sample_q, old_q;
	logic signed [SAMPLE_W-1:0]  ring_q [DEPTH];
	logic signed [SAMPLE_W-1:0]  sorted_q [DEPTH];
	logic signed [SAMPLE_W-1:0]  sorted_d [DEPTH];
	logic                        out_valid_q;
	logic signed [RESULT_W-1:0]  median_q, median_d;
	logic [LW-1:0]               idx_a, idx_b, len_new;
	logic [LW:0]                 ptr_inc;
	logic [DEPTH-1:0]            lt;

	always_comb begin
		if (cfg_len == '0) begin
			len_new = LW'(1);
		end else if (int'(cfg_len) > DEPTH) begin
			len_new = LW'(DEPTH);
		end else begin
			len_new = LW'(cfg_len);
		end
	end

	assign ptr_inc = (LW + 1)'(ptr_q) + (LW + 1)'(1);

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			lt[j] = (j < int'(fill_q)) && (sorted_q[j] < sample_q);
		end
		for (int j = 0; j < DEPTH; j++) begin
			sorted_d[j] = sorted_q[j];
			if (cmd.remove) begin
				if (j < DEPTH - 1 && j < int'(fill_q) && sorted_q[j] >= old_q) begin
					sorted_d[j] = sorted_q[(j < DEPTH - 1) ? j + 1 : j];
				end
			end else if (cmd.insert && !lt[j]) begin
				if (j == 0) begin
					sorted_d[j] = sample_q;
				end else if (lt[(j > 0) ? j - 1 : 0]) begin
					sorted_d[j] = sample_q;
				end else begin
					sorted_d[j] = sorted_q[(j > 0) ? j - 1 : 0];
				end
			end
		end
	end

	assign idx_a    = (len_q - LW'(1)) >> 1;
	assign idx_b    = len_q >> 1;
	assign median_d = RESULT_W'(sorted_q[idx_a[PW-1:0]]) + RESULT_W'(sorted_q[idx_b[PW-1:0]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LW'(LEN_RESET);
			fill_q      <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q  <= len_new;
				fill_q <= '0;
				ptr_q  <= '0;
			end
			if (cmd.take) begin
				if (in_start) begin
					fill_q <= '0;
				end
				if (in_start || (LW + 1)'(ptr_q) >= (LW + 1)'(len_q)) begin
					ptr_q <= '0;
				end
			end
			if (cmd.remove) begin
				fill_q <= fill_q - LW'(1);
			end
			if (cmd.insert) begin
				fill_q <= fill_q + LW'(1);
				ptr_q  <= (ptr_inc >= (LW + 1)'(len_q)) ? '0 : ptr_inc[PW-1:0];
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= in_sample;
		end
		if (cmd.read) begin
			old_q <= ring_q[ptr_q];
		end
		if (cmd.insert) begin
			ring_q[ptr_q] <= sample_q;
		end
		sorted_q <= sorted_d;
		if (cmd.emit) begin
			median_q <= median_d;
		end
	end

	assign sts.full      = fill_q >= len_q;
	assign sts.will_emit = (LW + 1)'(fill_q) + (LW + 1)'(1) >= (LW + 1)'(len_q);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_median    = median_q;
	assign len_rd        = CFG_W'(len_q);

	`include "sliding_window_median_assert.svh"

	`SWM_ASSERT(a_fill_le_len, fill_q <= len_q, "fill count exceeds window length")
	`SWM_ASSERT(a_ptr_lt_len, (LW + 1)'(ptr_q) < (LW + 1)'(len_q), "ring pointer out of window")
	`SWM_ASSERT_NEXT(a_insert_grows, cmd.insert && !cfg_we, fill_q == $past(fill_q) + LW'(1), "insert did not grow fill")
endmodule

@@ sv/sliding_window_median.sv @@
// Running median filter over the last window_length signed 32-bit samples
// (register 0, 1..WINDOW_DEPTH; writing it restarts the window). A sample
// with start_sequence set begins a new sequence. No result until the window
// holds window_length samples; after that every sample yields twice the
// median. While the window fills, a sample passes through accept, ring
// memory read of the oldest sample and a parallel insert over the sorted
// register array; the sample that fills it adds the output load, and once
// it is full a parallel remove comes before the insert. The output load
// waits while a previous result is still unaccepted. The result register
// lets the next sample in while a transfer is still pending.
module sliding_window_median #(
	parameter int WINDOW_DEPTH = swm_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	swm_in_if.sink                             in_ch,
	swm_out_if.source                          out_ch,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [swm_pkg::PADDR_W-1:0]        paddr,
	input  logic [swm_pkg::PDATA_W-1:0]        pwdata,
	output logic [swm_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import swm_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic              cfg_we;
	logic [CFG_W-1:0]  len_rd;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_LENGTH);
	assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? PDATA_W'(len_rd) : '0;

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swm_dp #(
		.DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_sample  (in_ch.sample),
		.in_start   (in_ch.start_sequence),
		.cfg_we     (cfg_we),
		.cfg_len    (pwdata[CFG_W-1:0]),
		.len_rd     (len_rd),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_median (out_ch.median_doubled)
	);
endmodule

@@ verif/sliding_window_median_tb.sv @@
`timescale 1ns / 100ps

module sliding_window_median_tb;
	import swm_pkg::*;

	typedef enum {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		logic [CFG_W-1:0]           len_code;
		logic signed [SAMPLE_W-1:0] smp;
		bit                         restart;
		bit                         typed;
		logic signed [RESULT_W-1:0] median2;
	} stim_row_t;

	localparam int MAX_LEN = DEPTH_DEF;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	swm_in_if  in_ch();
	swm_out_if out_ch();

	sliding_window_median uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// window state mirror
	int                         win_len;
	logic signed [SAMPLE_W-1:0] ring_mirror [MAX_LEN];
	int                         held;
	int                         slot;

	logic signed [RESULT_W-1:0] pending_medians [$];
	int sender_idle_pct;
	int receiver_stall_pct;
	int errors;
	int medians_seen;
	int samples_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL sliding_window_median");
		$finish;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			medians_seen++;
			if (pending_medians.size() == 0) begin
				errors++;
				$display("%0t unexpected median: expected none, got %0d", $time,
					out_ch.median_doubled);
			end else begin
				if (out_ch.median_doubled !== pending_medians[0]) begin
					errors++;
					$display("%0t median mismatch: expected %0d, got %0d", $time,
						pending_medians[0], out_ch.median_doubled);
				end
				void'(pending_medians.pop_front());
			end
		end
	end

	task automatic apply_length(input logic [CFG_W-1:0] code);
		int l;
		l = code;
		if (l == 0) l = 1;
		if (l > MAX_LEN) l = MAX_LEN;
		win_len = l;
		held = 0;
		slot = 0;
	endtask

	task automatic window_median(input logic signed [SAMPLE_W-1:0] s, input bit restart,
			output bit produced, output logic signed [RESULT_W-1:0] m2);
		logic signed [SAMPLE_W-1:0] srt [MAX_LEN];
		logic signed [SAMPLE_W-1:0] t;
		logic signed [RESULT_W-1:0] a, b;
		int j;
		if (restart) begin
			held = 0;
			slot = 0;
		end
		if (slot >= win_len) slot = 0;
		ring_mirror[slot] = s;
		slot++;
		if (slot >= win_len) slot = 0;
		if (held < win_len) held++;
		produced = (held >= win_len);
		m2 = '0;
		if (produced) begin
			for (int i = 0; i < win_len; i++) begin
				t = ring_mirror[i];
				j = i;
				while (j > 0 && srt[j-1] > t) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = t;
			end
			if (win_len % 2) begin
				a = srt[(win_len-1)/2];
				m2 = a + a;
			end else begin
				a = srt[win_len/2-1];
				b = srt[win_len/2];
				m2 = a + b;
			end
		end
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_length(input logic [CFG_W-1:0] code);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_WINDOW_LENGTH;
		pwdata  <= PDATA_W'(code);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_length(code);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit restart,
			input bit typed, input logic signed [RESULT_W-1:0] typed_m2);
		bit produced;
		logic signed [RESULT_W-1:0] m2;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.sample         <= s;
		in_ch.start_sequence <= restart;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		samples_sent++;
		window_median(s, restart, produced, m2);
		if (produced) pending_medians = {pending_medians, (typed ? typed_m2 : m2)};
		else if (typed) begin
			errors++;
			$display("%0t table row expects %0d but the window is still filling",
				$time, typed_m2);
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(3))
			0: pick_sample = $urandom;
			1: pick_sample = $signed($urandom_range(16)) - 8;
			2: pick_sample = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: pick_sample = $signed($urandom_range(2000)) - 1000;
		endcase
	endfunction

	stim_row_t stim_table [$];
	int lengths [] = '{1, 2, 3, 5, 8, 17, 64, 63, 4, 127};

	initial begin
		arst_n = 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.sample         <= '0;
		in_ch.start_sequence <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		errors = 0;
		medians_seen = 0;
		samples_sent = 0;
		apply_length(CFG_W'(LEN_RESET));

		stim_table = '{
			'{ROW_SAMPLE, 0, 32'sd4, 0, 0, 0},
			'{ROW_SAMPLE, 0, -32'sd2, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sd9, 0, 1, 33'sd8},
			'{ROW_CFG, 7'd0, 0, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sh7fffffff, 0, 1, 33'sd4294967294},
			'{ROW_SAMPLE, 0, 32'sh80000000, 0, 1, 33'sh100000000},
			'{ROW_SAMPLE, 0, -32'sd1, 0, 1, -33'sd2},
			'{ROW_SAMPLE, 0, 32'sd0, 1, 1, 33'sd0},
			'{ROW_CFG, 7'd2, 0, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sh7fffffff, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sh7fffffff, 0, 1, 33'sd4294967294},
			'{ROW_SAMPLE, 0, 32'sh80000000, 0, 1, -33'sd1},
			'{ROW_SAMPLE, 0, 32'sh80000000, 0, 1, 33'sh100000000},
			'{ROW_SAMPLE, 0, 32'sd5, 1, 0, 0},
			'{ROW_SAMPLE, 0, -32'sd9, 0, 0, 0},
			'{ROW_CFG, 7'd100, 0, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sd1, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sd2, 0, 0, 0},
			'{ROW_CFG, 7'd3, 0, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sd30, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sd10, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sd20, 0, 0, 0},
			'{ROW_SAMPLE, 0, 32'sd20, 0, 0, 0},
			'{ROW_SAMPLE, 0, -32'sd7, 1, 0, 0}
		};

		repeat (12) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) write_length(stim_table[i].len_code);
			else send_sample(stim_table[i].smp, stim_table[i].restart,
				stim_table[i].typed, stim_table[i].median2);
		end

		for (int ph = 0; ph < 10; ph++) begin
			write_length(CFG_W'(lengths[ph]));
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
				default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
			endcase
			for (int k = 0; k < 35 + win_len; k++) begin
				if (k == 20 && ph == 2) drain();
				send_sample(pick_sample(), ($urandom_range(99) < 3), 0, 0);
			end
		end
		sender_idle_pct = 0;
		receiver_stall_pct = 0;

		in_ch.valid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d samples and %0d medians over window lengths 1 to 64,",
			samples_sent, medians_seen);
		$display("with restarts, extremes and sender/receiver idling.");
		if (errors == 0) begin
			$display("PASS sliding_window_median");
		end else begin
			$display("FAIL sliding_window_median");
		end
		$finish;
	end
endmodule
